// ===== hdl/mssfl_pkg.sv =====
// package: sizes, codes and types of the multi-stack shared free list core
`default_nettype none
package mssfl_pkg;

   localparam int NUM_STACKS = 4;
   localparam int NUM_SLOTS  = 16;

   localparam int STACK_NUM_W = 3;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int STK_W       = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PTR_W       = $clog2(NUM_SLOTS + 1);

   localparam int REQ_DATA_W  = ((STACK_NUM_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((VALUE_W + 7) / 8) * 8;

   localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(NUM_SLOTS);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_BAD_STACK = 2'd3
   } status_type;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [VALUE_W-1:0] value_type;

endpackage
`default_nettype wire

// ===== hdl/multi_stack_shared_free_list_core.sv =====
// top level: several stacks sharing one slot store through a linked free list
//
//  channel | dir | tdata (low bit up)          | tuser
//  req_    | in  | stack_num[3], push_value[32] | op (0 push, 1 pop)
//  rsp_    | out | pop_value[32]                | status
//
// a word is registered on acceptance and, once the result register is free,
// resolved into the result register, so a result passes both registers
// one word per cycle while results are not stalled: tops, links and values sit
// in flip-flops; the top/free pointer read and dependent link read are combinational
// reset clears all stacks and rebuilds the free list at once, no sweep
// a stalled result holds the input register; the request side stalls only then
`default_nettype none
module multi_stack_shared_free_list_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [mssfl_pkg::REQ_DATA_W-1:0] req_tdata,  // stack_num, push_value, zero pad
   input  wire                              req_tuser,  // op
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [mssfl_pkg::RSP_DATA_W-1:0] rsp_tdata,  // pop_value
   output logic [mssfl_pkg::STATUS_W-1:0]   rsp_tuser   // status
);
   import mssfl_pkg::*;

   logic                   in_valid_ff;
   logic                   in_op_ff;
   logic [STACK_NUM_W-1:0] in_stack_ff;
   value_type              in_value_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff, rsp_status_in;
   value_type              rsp_value_ff, rsp_value_in;

   ptr_type                tops_ff   [NUM_STACKS];
   ptr_type                links_ff  [NUM_SLOTS];
   value_type              values_ff [NUM_SLOTS];
   ptr_type                free_head_ff, free_head_in;

   logic                   fire;
   logic                   stack_ok;
   logic                   is_push;
   logic [STK_W-1:0]       stk_sel;
   ptr_type                top_rd;
   ptr_type                slot_ptr;
   logic [IDX_W-1:0]       slot_idx;
   ptr_type                link_rd;
   logic                   do_update;
   ptr_type                link_wr_data;
   ptr_type                top_wr_data;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   assign stack_ok = (32'(in_stack_ff) < NUM_STACKS);
   assign is_push  = (in_op_ff == OP_PUSH);
   assign stk_sel  = STK_W'(in_stack_ff);
   assign top_rd   = tops_ff[stk_sel];
   assign slot_ptr = is_push ? free_head_ff : top_rd;
   assign slot_idx = slot_ptr[IDX_W-1:0];
   assign link_rd  = links_ff[slot_idx];

   assign link_wr_data = is_push ? top_rd : free_head_ff;
   assign top_wr_data  = is_push ? free_head_ff : link_rd;

   always_comb begin
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      do_update     = 1'b0;
      free_head_in  = free_head_ff;
      if (!stack_ok) begin
         rsp_status_in = ST_BAD_STACK;
      end else if (slot_ptr == PTR_NULL) begin
         rsp_status_in = is_push ? ST_FULL : ST_EMPTY;
      end else begin
         do_update    = 1'b1;
         free_head_in = is_push ? link_rd : top_rd;
         if (!is_push) begin
            rsp_value_in = values_ff[slot_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff    <= req_tuser;
         in_stack_ff <= req_tdata[STACK_NUM_W-1:0];
         in_value_ff <= req_tdata[STACK_NUM_W+VALUE_W-1:STACK_NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         for (int i = 0; i < NUM_STACKS; i++) begin
            tops_ff[i] <= PTR_NULL;
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            links_ff[i] <= (i == NUM_SLOTS - 1) ? PTR_NULL : PTR_W'(i + 1);
         end
      end else if (fire && do_update) begin
         free_head_ff      <= free_head_in;
         tops_ff[stk_sel]  <= top_wr_data;
         links_ff[slot_idx] <= link_wr_data;
      end
   end

   // value store has no reset, written on pushes only
   always_ff @(posedge clock) begin
      if (fire && do_update && is_push) begin
         values_ff[slot_idx] <= in_value_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

// ===== hdl/mssfl_checker.sv =====
// port checker for the multi-stack shared free list core, bound to the top level
`default_nettype none
module mssfl_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire  [mssfl_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire                              req_tuser,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire  [mssfl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire  [mssfl_pkg::STATUS_W-1:0]   rsp_tuser
);
   import mssfl_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // failed operations never carry a value; successful pushes also return zero but fall outside this check
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
      else $error("nonzero value on failed operation");

   // request side stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without result backpressure");

   // accepted word passes the input register and shows as a result when the output is free
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("result missing after accepted request");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind multi_stack_shared_free_list_core mssfl_checker u_mssfl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
